FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, sampled on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define RDMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// overlapping implication
`define RDMC_ASSERT_IMPL(lbl, ante, cons, msg) \
  `RDMC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: design/rdmc_pkg.sv
// ----------------------------------------------------------------------------
// rdmc_pkg
// Types and constants shared by the maze carver controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rdmc_pkg;

  localparam int COORD_W    = 5;
  localparam int COORD_SPAN = 32;
  localparam int DIR_IDX_W  = 2;
  localparam int MASK_W     = 4;
  localparam int SIZE_W     = 6;
  localparam int NUM_DIRS   = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic [DIR_IDX_W-1:0] DIR_NORTH = 2'd0;
  localparam logic [DIR_IDX_W-1:0] DIR_SOUTH = 2'd1;
  localparam logic [DIR_IDX_W-1:0] DIR_EAST  = 2'd2;
  localparam logic [DIR_IDX_W-1:0] DIR_WEST  = 2'd3;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_EDGE    = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_STARTED = 3'd2,
    KIND_READ    = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    GRD_RD_NONE = 2'd0,
    GRD_RD_CELL = 2'd1,
    GRD_RD_NB   = 2'd2,
    GRD_RD_ITEM = 2'd3
  } grd_rd_e;

  typedef enum logic [1:0] {
    GRD_WR_NONE  = 2'd0,
    GRD_WR_CLEAR = 2'd1,
    GRD_WR_CELL  = 2'd2,
    GRD_WR_NB    = 2'd3
  } grd_wr_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic [1:0]           swap_pick_three;
    logic [1:0]           swap_pick_two;
    logic                 swap_pick_one;
  } in_t;

  typedef struct packed {
    kind_e                kind;
    logic [COORD_W-1:0]   from_x;
    logic [COORD_W-1:0]   from_y;
    logic [MASK_W-1:0]    carve_dir;
    logic [COORD_W-1:0]   to_x;
    logic [COORD_W-1:0]   to_y;
    logic [MASK_W-1:0]    cell_mask;
  } out_t;

  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [DIR_IDX_W-1:0] d;
  } stk_entry_t;

  typedef struct packed {
    logic    load_item;
    logic    cnt_clear;
    logic    base_start;
    logic    base_nb;
    logic    push;
    logic    pop;
    grd_rd_e grd_rd;
    grd_wr_e grd_wr;
    logic    emit;
    kind_e   emit_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_e opcode;
    logic    start_ok;
    logic    read_ok;
    logic    stack_empty;
    logic    geo_ok;
    logic    cell_seen;
    logic    nb_free;
    logic    clr_last;
    logic    push_last;
  } dp_stat_t;

  function automatic logic [MASK_W-1:0] dir_bit(input logic [DIR_IDX_W-1:0] d);
    return MASK_W'(1) << d;
  endfunction

endpackage

`default_nettype wire

FILE: design/rdmc_ctrl.sv
// ----------------------------------------------------------------------------
// rdmc_ctrl
// Sequencer for start, carve step and read commands of the maze carver.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rdmc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire rdmc_pkg::dp_stat_t   stat_i,
  output rdmc_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_PUSH,
    S_POP,
    S_LOOK,
    S_CELL,
    S_NB,
    S_WRNB,
    S_READ
  } state_e;

  state_e state_q, state_d;
  logic   is_start_q, is_start_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    is_start_d = is_start_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.opcode)
          rdmc_pkg::OP_START: begin
            if (stat_i.start_ok) begin
              cmd_o.cnt_clear  = 1'b1;
              cmd_o.base_start = 1'b1;
              is_start_d       = 1'b1;
              state_d          = S_CLEAR;
            end else begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = rdmc_pkg::KIND_REJECT;
              state_d         = S_IDLE;
            end
          end
          rdmc_pkg::OP_STEP: state_d = S_POP;
          rdmc_pkg::OP_READ: begin
            if (stat_i.read_ok) cmd_o.grd_rd = rdmc_pkg::GRD_RD_ITEM;
            state_d = S_READ;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_READ: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = rdmc_pkg::KIND_READ;
        state_d         = S_IDLE;
      end
      S_CLEAR: begin
        cmd_o.grd_wr = rdmc_pkg::GRD_WR_CLEAR;
        if (stat_i.clr_last) state_d = is_start_q ? S_PUSH : S_IDLE;
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        if (stat_i.push_last) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = is_start_q ? rdmc_pkg::KIND_STARTED : rdmc_pkg::KIND_EDGE;
          is_start_d      = 1'b0;
          state_d         = S_IDLE;
        end
      end
      S_POP: begin
        if (stat_i.stack_empty) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = rdmc_pkg::KIND_DONE;
          state_d         = S_IDLE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat_i.geo_ok) begin
          cmd_o.grd_rd = rdmc_pkg::GRD_RD_CELL;
          state_d      = S_CELL;
        end else begin
          state_d = S_POP;
        end
      end
      S_CELL: begin
        if (stat_i.cell_seen) begin
          state_d = S_POP;
        end else begin
          cmd_o.grd_rd = rdmc_pkg::GRD_RD_NB;
          state_d      = S_NB;
        end
      end
      S_NB: begin
        if (stat_i.nb_free) begin
          cmd_o.grd_wr = rdmc_pkg::GRD_WR_CELL;
          state_d      = S_WRNB;
        end else begin
          state_d = S_POP;
        end
      end
      S_WRNB: begin
        cmd_o.grd_wr  = rdmc_pkg::GRD_WR_NB;
        cmd_o.base_nb = 1'b1;
        state_d       = S_PUSH;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      is_start_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      is_start_q <= is_start_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  `RDMC_ASSERT_IMPL(a_pop_nonempty, cmd_o.pop, !stat_i.stack_empty, "pop on empty stack")
  `RDMC_ASSERT_IMPL(a_accept_busy, start_i && !busy_o, ##1 busy_o, "busy not raised after beat")

endmodule

`default_nettype wire

FILE: design/rdmc_dp.sv
// ----------------------------------------------------------------------------
// rdmc_dp
// Maze carver datapath: config registers, side-mask grid RAM, step stack RAM,
// neighbor geometry, shuffle and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rdmc_dp #(
  parameter int MAX_COLS    = 32,
  parameter int MAX_ROWS    = 32,
  parameter int STACK_DEPTH = 4096
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  input  wire logic [rdmc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [rdmc_pkg::SIZE_W-1:0]           cfg_data_i,
  input  wire rdmc_pkg::in_t                         item_i,
  input  wire rdmc_pkg::ctrl_cmd_t                   cmd_i,
  output rdmc_pkg::dp_stat_t                         stat_o,
  output logic                                       result_valid_o,
  output rdmc_pkg::out_t                             result_o
);

  localparam int COLS_U = (MAX_COLS < rdmc_pkg::COORD_SPAN) ? MAX_COLS : rdmc_pkg::COORD_SPAN;
  localparam int ROWS_U = (MAX_ROWS < rdmc_pkg::COORD_SPAN) ? MAX_ROWS : rdmc_pkg::COORD_SPAN;
  localparam int GDEPTH = COLS_U * ROWS_U;
  localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int CW     = $clog2(STACK_DEPTH + 1);
  localparam int SW     = rdmc_pkg::SIZE_W;
  localparam int XW     = rdmc_pkg::COORD_W;
  localparam int MW     = rdmc_pkg::MASK_W;
  localparam int DW     = rdmc_pkg::DIR_IDX_W;
  localparam int EW     = $bits(rdmc_pkg::stk_entry_t);
  localparam int PW     = 2 * rdmc_pkg::COORD_W + 1;

  typedef logic [rdmc_pkg::NUM_DIRS-1:0][DW-1:0] order_t;

  function automatic logic [GAW-1:0] gaddr(input logic [XW-1:0] x, input logic [XW-1:0] y);
    logic [PW-1:0] sum;
    sum = PW'(y) * PW'(COLS_U) + PW'(x);
    return sum[GAW-1:0];
  endfunction

  function automatic order_t shuffle(input logic [1:0] p3, input logic [1:0] p2,
                                     input logic p1);
    order_t        o;
    logic [DW-1:0] t;
    logic [1:0]    j2;
    o[0] = rdmc_pkg::DIR_NORTH;
    o[1] = rdmc_pkg::DIR_SOUTH;
    o[2] = rdmc_pkg::DIR_EAST;
    o[3] = rdmc_pkg::DIR_WEST;
    t = o[3]; o[3] = o[p3]; o[p3] = t;
    j2 = (p2 == 2'd3) ? 2'd0 : p2;
    t = o[2]; o[2] = o[j2]; o[j2] = t;
    t = o[1]; o[1] = o[p1]; o[p1] = t;
    return o;
  endfunction

  logic [SW-1:0]          gw_q, gh_q;
  rdmc_pkg::in_t          item_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [GAW-1:0]         clr_q;
  logic [1:0]             pidx_q;
  logic [XW-1:0]          px_q, py_q;
  logic [MW-1:0]          cellm_q;
  logic [MW-1:0]          grd_rd_q;
  rdmc_pkg::stk_entry_t   stk_rd_q;
  logic                   result_valid_q;
  rdmc_pkg::out_t         result_q, result_d;

  logic [MW-1:0]          grid_mem [GDEPTH];
  logic [EW-1:0]          stk_mem  [STACK_DEPTH];

  logic [SW-1:0]          w_eff, h_eff;
  logic [SW-1:0]          nx, ny;
  logic                   edge_ok, inb;
  logic [MW-1:0]          dbit, nbit;
  logic [GAW-1:0]         cell_addr, nb_addr, item_addr;
  logic [GAW-1:0]         grd_raddr, grd_waddr;
  logic [MW-1:0]          grd_wdata;
  logic                   grd_re, grd_we;
  logic                   full, push_we;
  logic [CW-1:0]          pop_cnt;
  order_t                 order;
  rdmc_pkg::stk_entry_t   push_entry;
  logic                   item_ok;

  assign w_eff = (gw_q > SW'(COLS_U)) ? SW'(COLS_U) : gw_q;
  assign h_eff = (gh_q > SW'(ROWS_U)) ? SW'(ROWS_U) : gh_q;

  assign item_ok = ({1'b0, item_q.cell_x} < w_eff) && ({1'b0, item_q.cell_y} < h_eff);

  always_comb begin
    nx      = {1'b0, stk_rd_q.x};
    ny      = {1'b0, stk_rd_q.y};
    edge_ok = 1'b1;
    case (stk_rd_q.d)
      rdmc_pkg::DIR_NORTH: begin
        edge_ok = (stk_rd_q.y != '0);
        ny      = {1'b0, stk_rd_q.y} - SW'(1);
      end
      rdmc_pkg::DIR_SOUTH: ny = {1'b0, stk_rd_q.y} + SW'(1);
      rdmc_pkg::DIR_EAST:  nx = {1'b0, stk_rd_q.x} + SW'(1);
      rdmc_pkg::DIR_WEST: begin
        edge_ok = (stk_rd_q.x != '0);
        nx      = {1'b0, stk_rd_q.x} - SW'(1);
      end
      default: edge_ok = 1'b0;
    endcase
  end

  assign inb  = ({1'b0, stk_rd_q.x} < SW'(COLS_U)) && ({1'b0, stk_rd_q.y} < SW'(ROWS_U));
  assign dbit = rdmc_pkg::dir_bit(stk_rd_q.d);
  assign nbit = rdmc_pkg::dir_bit(stk_rd_q.d ^ DW'(1));

  assign cell_addr = gaddr(stk_rd_q.x, stk_rd_q.y);
  assign nb_addr   = gaddr(nx[XW-1:0], ny[XW-1:0]);
  assign item_addr = gaddr(item_q.cell_x, item_q.cell_y);

  always_comb begin
    grd_re    = 1'b1;
    grd_raddr = item_addr;
    case (cmd_i.grd_rd)
      rdmc_pkg::GRD_RD_CELL: grd_raddr = cell_addr;
      rdmc_pkg::GRD_RD_NB:   grd_raddr = nb_addr;
      rdmc_pkg::GRD_RD_ITEM: grd_raddr = item_addr;
      default:               grd_re    = 1'b0;
    endcase
  end

  always_comb begin
    grd_we    = 1'b1;
    grd_waddr = clr_q;
    grd_wdata = '0;
    case (cmd_i.grd_wr)
      rdmc_pkg::GRD_WR_CLEAR: begin
        grd_waddr = clr_q;
        grd_wdata = '0;
      end
      rdmc_pkg::GRD_WR_CELL: begin
        grd_waddr = cell_addr;
        grd_wdata = cellm_q | dbit;
      end
      rdmc_pkg::GRD_WR_NB: begin
        grd_waddr = nb_addr;
        grd_wdata = nbit;
      end
      default: grd_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (grd_we) grid_mem[grd_waddr] <= grd_wdata;
    if (grd_re) grd_rd_q <= grid_mem[grd_raddr];
    if (cmd_i.grd_rd == rdmc_pkg::GRD_RD_NB) cellm_q <= grd_rd_q;
  end

  assign order      = shuffle(item_q.swap_pick_three, item_q.swap_pick_two,
                              item_q.swap_pick_one);
  assign push_entry = '{x: px_q, y: py_q, d: order[pidx_q]};
  assign full       = (cnt_q == CW'(STACK_DEPTH));
  assign push_we    = cmd_i.push && !full;
  assign pop_cnt    = cnt_q - CW'(1);

  always_ff @(posedge clk_i) begin
    if (push_we) stk_mem[cnt_q[SAW-1:0]] <= push_entry;
    if (cmd_i.pop) stk_rd_q <= rdmc_pkg::stk_entry_t'(stk_mem[pop_cnt[SAW-1:0]]);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clear)  cnt_d = '0;
    else if (push_we)     cnt_d = cnt_q + CW'(1);
    else if (cmd_i.pop)   cnt_d = pop_cnt;
  end

  always_comb begin
    result_d      = '0;
    result_d.kind = cmd_i.emit_kind;
    case (cmd_i.emit_kind)
      rdmc_pkg::KIND_EDGE: begin
        result_d.from_x    = stk_rd_q.x;
        result_d.from_y    = stk_rd_q.y;
        result_d.carve_dir = dbit;
        result_d.to_x      = nx[XW-1:0];
        result_d.to_y      = ny[XW-1:0];
      end
      rdmc_pkg::KIND_READ: result_d.cell_mask = item_ok ? grd_rd_q : '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q           <= rdmc_pkg::GRID_SIZE_RESET;
      gh_q           <= rdmc_pkg::GRID_SIZE_RESET;
      cnt_q          <= '0;
      clr_q          <= '0;
      pidx_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rdmc_pkg::CFG_GRID_WIDTH:  gw_q <= cfg_data_i;
          rdmc_pkg::CFG_GRID_HEIGHT: gh_q <= cfg_data_i;
          default: ;
        endcase
      end
      cnt_q <= cnt_d;
      if (cmd_i.grd_wr == rdmc_pkg::GRD_WR_CLEAR) begin
        clr_q <= stat_o.clr_last ? '0 : clr_q + GAW'(1);
      end
      if (cmd_i.push) pidx_q <= pidx_q + 2'd1;
      result_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
    if (cmd_i.base_start) begin
      px_q <= item_q.cell_x;
      py_q <= item_q.cell_y;
    end else if (cmd_i.base_nb) begin
      px_q <= nx[XW-1:0];
      py_q <= ny[XW-1:0];
    end
    if (cmd_i.emit) result_q <= result_d;
  end

  always_comb begin
    stat_o             = '0;
    stat_o.opcode      = item_q.opcode;
    stat_o.start_ok    = item_ok;
    stat_o.read_ok     = item_ok;
    stat_o.stack_empty = (cnt_q == '0);
    stat_o.geo_ok      = inb && edge_ok && (nx < w_eff) && (ny < h_eff);
    stat_o.cell_seen   = |(grd_rd_q & dbit);
    stat_o.nb_free     = (grd_rd_q == '0);
    stat_o.clr_last    = (clr_q == GAW'(GDEPTH - 1));
    stat_o.push_last   = (pidx_q == 2'd3);
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `RDMC_ASSERT(a_cnt_bound, cnt_q <= CW'(STACK_DEPTH), "stack count past depth")
  `RDMC_ASSERT_IMPL(a_edge_onehot, result_valid_q && (result_q.kind == rdmc_pkg::KIND_EDGE), $onehot(result_q.carve_dir), "carved direction not one-hot")

endmodule

`default_nettype wire

FILE: design/random_dfs_maze_carver.sv
// ----------------------------------------------------------------------------
// random_dfs_maze_carver
// Depth-first maze carver with an explicit (cell, direction) stack.
//
// Channel   Direction  Handshake                 Beat
// item      in         start_i & !busy_o         item_i (in_t)
// result    out        result_valid_o strobe     result_o (out_t)
// config    in         cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// Read: decode, then the result with the cell mask. A rejected start answers from decode.
// Start: decode, grid clear sweep over min(MAX_COLS,32)*min(MAX_ROWS,32) cells,
//   then pushes of every direction in shuffled order. Step: pops entries and
//   drops those off the grid, already carved or aiming at a visited cell, then
//   carves and pushes, or reports done. Reset: grid clear sweep with busy_o high.
// Results are a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module random_dfs_maze_carver #(
  parameter int MAX_COLS    = 32,
  parameter int MAX_ROWS    = 32,
  parameter int STACK_DEPTH = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire rdmc_pkg::in_t                    item_i,
  output logic                                  result_valid_o,
  output rdmc_pkg::out_t                        result_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [rdmc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [rdmc_pkg::SIZE_W-1:0]      cfg_data_i
);

  rdmc_pkg::ctrl_cmd_t cmd;
  rdmc_pkg::dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  rdmc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  rdmc_dp #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives random_dfs_maze_carver with command beats and grid size writes,
// predicts every result from its own copy of the grid masks and the step
// stack, and checks each result strobe field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------

module testbench;

  localparam int ITEM_GOAL     = 1050;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 64;
  localparam int GRID_CELLS    = rdmc_pkg::COORD_SPAN * rdmc_pkg::COORD_SPAN;
  localparam int STACK_SLOTS   = 4096;

  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CFG,
    ACT_DRAIN
  } act_e;

  typedef struct {
    act_e                           kind;
    rdmc_pkg::in_t                  item;
    int                             gap;
    logic [rdmc_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [rdmc_pkg::SIZE_W-1:0]    reg_val;
  } work_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           start_i     = 1'b0;
  rdmc_pkg::in_t                  item_i      = '0;
  logic                           cfg_valid_i = 1'b0;
  logic [rdmc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [rdmc_pkg::SIZE_W-1:0]    cfg_data_i  = '0;
  logic                           busy_o;
  logic                           result_valid_o;
  rdmc_pkg::out_t                 result_o;
  logic                           cfg_ready_o;

  random_dfs_maze_carver u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  work_t          work_q[$];
  rdmc_pkg::out_t outcomes_due[$];

  logic [rdmc_pkg::MASK_W-1:0] mdl_mask  [GRID_CELLS]  = '{default: '0};
  rdmc_pkg::stk_entry_t        mdl_stack [STACK_SLOTS] = '{default: '0};
  int                          mdl_depth = 0;
  logic [rdmc_pkg::SIZE_W-1:0] mdl_cols  = rdmc_pkg::GRID_SIZE_RESET;
  logic [rdmc_pkg::SIZE_W-1:0] mdl_rows  = rdmc_pkg::GRID_SIZE_RESET;

  int fault_cnt      = 0;
  int item_total     = 0;
  int queued_total   = 0;
  int accepted_total = 0;
  int idle_max       = 12;
  int gap_left       = 0;
  int settle_cnt     = 0;

  function automatic void push_dirs(input int x, input int y, input rdmc_pkg::in_t it);
    logic [rdmc_pkg::DIR_IDX_W-1:0] order [rdmc_pkg::NUM_DIRS];
    logic [rdmc_pkg::DIR_IDX_W-1:0] j;
    logic [rdmc_pkg::DIR_IDX_W-1:0] t;
    order = '{rdmc_pkg::DIR_NORTH, rdmc_pkg::DIR_SOUTH, rdmc_pkg::DIR_EAST,
              rdmc_pkg::DIR_WEST};
    j = it.swap_pick_three;
    t = order[3]; order[3] = order[j]; order[j] = t;
    j = (it.swap_pick_two == 2'd3) ? 2'd0 : it.swap_pick_two;
    t = order[2]; order[2] = order[j]; order[j] = t;
    j = {1'b0, it.swap_pick_one};
    t = order[1]; order[1] = order[j]; order[j] = t;
    for (int k = 0; k < rdmc_pkg::NUM_DIRS; k++) begin
      if (mdl_depth < STACK_SLOTS) begin
        mdl_stack[mdl_depth] = '{x: x[rdmc_pkg::COORD_W-1:0], y: y[rdmc_pkg::COORD_W-1:0],
                                 d: order[k]};
        mdl_depth++;
      end
    end
  endfunction

  function automatic rdmc_pkg::out_t next_outcome(input rdmc_pkg::in_t it,
                                                  output bit produced);
    rdmc_pkg::out_t                 res;
    rdmc_pkg::stk_entry_t           ent;
    int                             w, h, cx, cy, nx, ny;
    logic [rdmc_pkg::DIR_IDX_W-1:0] d;
    res = '0;
    produced = 1'b1;
    w = (mdl_cols > rdmc_pkg::COORD_SPAN) ? rdmc_pkg::COORD_SPAN : int'(mdl_cols);
    h = (mdl_rows > rdmc_pkg::COORD_SPAN) ? rdmc_pkg::COORD_SPAN : int'(mdl_rows);
    case (it.opcode)
      rdmc_pkg::OP_START: begin
        if (int'(it.cell_x) >= w || int'(it.cell_y) >= h) begin
          res.kind = rdmc_pkg::KIND_REJECT;
        end else begin
          mdl_mask = '{default: '0};
          mdl_depth = 0;
          push_dirs(it.cell_x, it.cell_y, it);
          res.kind = rdmc_pkg::KIND_STARTED;
        end
      end
      rdmc_pkg::OP_STEP: begin
        res.kind = rdmc_pkg::KIND_DONE;
        while (mdl_depth > 0) begin
          mdl_depth--;
          ent = mdl_stack[mdl_depth];
          cx = ent.x;
          cy = ent.y;
          d  = ent.d;
          if (mdl_mask[cy * rdmc_pkg::COORD_SPAN + cx][d]) continue;
          nx = cx;
          ny = cy;
          case (d)
            rdmc_pkg::DIR_NORTH: ny = cy - 1;
            rdmc_pkg::DIR_SOUTH: ny = cy + 1;
            rdmc_pkg::DIR_EAST:  nx = cx + 1;
            default:             nx = cx - 1;
          endcase
          if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
          if (mdl_mask[ny * rdmc_pkg::COORD_SPAN + nx] != '0) continue;
          mdl_mask[cy * rdmc_pkg::COORD_SPAN + cx][d] = 1'b1;
          mdl_mask[ny * rdmc_pkg::COORD_SPAN + nx][d ^ 2'd1] = 1'b1;
          push_dirs(nx, ny, it);
          res.kind      = rdmc_pkg::KIND_EDGE;
          res.from_x    = cx[rdmc_pkg::COORD_W-1:0];
          res.from_y    = cy[rdmc_pkg::COORD_W-1:0];
          res.carve_dir = 4'b0001 << d;
          res.to_x      = nx[rdmc_pkg::COORD_W-1:0];
          res.to_y      = ny[rdmc_pkg::COORD_W-1:0];
          break;
        end
      end
      rdmc_pkg::OP_READ: begin
        res.kind = rdmc_pkg::KIND_READ;
        if (int'(it.cell_x) < w && int'(it.cell_y) < h)
          res.cell_mask = mdl_mask[int'(it.cell_y) * rdmc_pkg::COORD_SPAN + int'(it.cell_x)];
      end
      default: produced = 1'b0;
    endcase
    return res;
  endfunction

  function automatic void log_fault(input string what, input rdmc_pkg::out_t want,
                                    input rdmc_pkg::out_t got);
    fault_cnt++;
    if (fault_cnt <= 10)
      $display("%0t %s: expected kind %0d from (%0d,%0d) dir %0h to (%0d,%0d) mask %0h,",
               $time, what, want.kind, want.from_x, want.from_y, want.carve_dir, want.to_x,
               want.to_y, want.cell_mask,
               " got kind %0d from (%0d,%0d) dir %0h to (%0d,%0d) mask %0h",
               got.kind, got.from_x, got.from_y, got.carve_dir, got.to_x, got.to_y,
               got.cell_mask);
  endfunction

  function automatic void queue_item(input rdmc_pkg::opcode_e op, input int x, input int y,
                                     input int p3, input int p2, input int p1);
    work_t w;
    w = '{kind: ACT_ITEM, item: '0, gap: $urandom_range(0, idle_max), reg_idx: '0,
          reg_val: '0};
    w.item.opcode          = op;
    w.item.cell_x          = x[rdmc_pkg::COORD_W-1:0];
    w.item.cell_y          = y[rdmc_pkg::COORD_W-1:0];
    w.item.swap_pick_three = p3[1:0];
    w.item.swap_pick_two   = p2[1:0];
    w.item.swap_pick_one   = p1[0];
    work_q.push_back(w);
    queued_total++;
    if (op != rdmc_pkg::OP_NONE) item_total++;
  endfunction

  function automatic void queue_ctl(input act_e kind,
                                    input logic [rdmc_pkg::CFG_IDX_W-1:0] idx,
                                    input int val);
    work_q.push_back('{kind: kind, item: '0, gap: 0, reg_idx: idx,
                       reg_val: val[rdmc_pkg::SIZE_W-1:0]});
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 84) return 0;
    if (r < 88) return 32;
    if (r < 92) return 63;
    return $urandom_range(0, 63);
  endfunction

  function automatic int pick_coord(input int span);
    if (span > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, span - 1);
    return $urandom_range(0, rdmc_pkg::COORD_SPAN - 1);
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(20_000_000);
    $display("random_dfs_maze_carver: mismatch");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin : item_driver
    rdmc_pkg::out_t want;
    bit             produced;
    bit             next_start;
    bit             next_cfg;
    work_t          w;
    if (!rst_ni) begin
      start_i     <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        accepted_total++;
        want = next_outcome(item_i, produced);
        if (produced) outcomes_due.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == rdmc_pkg::CFG_GRID_WIDTH) mdl_cols = cfg_data_i;
        else mdl_rows = cfg_data_i;
      end
      next_start = start_i && busy_o;
      next_cfg   = cfg_valid_i && !cfg_ready_o;
      if (!next_start && !next_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (work_q.size() > 0) begin
          w = work_q[0];
          case (w.kind)
            ACT_ITEM: begin
              item_i <= w.item;
              next_start = 1'b1;
              gap_left = w.gap;
              void'(work_q.pop_front());
            end
            ACT_CFG: begin
              cfg_index_i <= w.reg_idx;
              cfg_data_i  <= w.reg_val;
              next_cfg = 1'b1;
              void'(work_q.pop_front());
            end
            default: begin
              if (outcomes_due.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt >= SETTLE_CYCLES) begin
                settle_cnt = 0;
                void'(work_q.pop_front());
              end else begin
                settle_cnt++;
              end
            end
          endcase
        end
      end
      start_i     <= next_start;
      cfg_valid_i <= next_cfg;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    rdmc_pkg::out_t want;
    if (rst_ni && result_valid_o) begin
      if (outcomes_due.size() == 0) begin
        log_fault("unexpected result", '0, result_o);
      end else begin
        want = outcomes_due.pop_front();
        if (result_o.kind !== want.kind || result_o.from_x !== want.from_x ||
            result_o.from_y !== want.from_y || result_o.carve_dir !== want.carve_dir ||
            result_o.to_x !== want.to_x || result_o.to_y !== want.to_y ||
            result_o.cell_mask !== want.cell_mask)
          log_fault("result mismatch", want, result_o);
      end
    end
  end

  initial begin : stimulus
    int plan_w [8];
    int plan_h [8];
    int cur_w, cur_h, w_eff, h_eff, n_steps, r, phase;
    plan_w = '{32, 63, 1, 0, 16, 1, 33, 2};
    plan_h = '{32, 1, 32, 16, 0, 1, 2, 63};
    cur_w = rdmc_pkg::GRID_SIZE_RESET;
    cur_h = rdmc_pkg::GRID_SIZE_RESET;

    queue_item(rdmc_pkg::OP_READ, 0, 0, 0, 0, 0);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 3, 3, 1);
    queue_item(rdmc_pkg::OP_NONE, 31, 31, 3, 3, 1);
    queue_item(rdmc_pkg::OP_START, 16, 3, 0, 0, 0);
    queue_item(rdmc_pkg::OP_START, 3, 16, 0, 0, 0);
    queue_item(rdmc_pkg::OP_START, 31, 31, 3, 3, 1);
    queue_item(rdmc_pkg::OP_START, 15, 15, 3, 3, 1);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 0, 0, 0);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 1, 1, 0);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 2, 2, 1);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 3, 3, 1);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 0, 3, 0);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 3, 0, 1);
    queue_item(rdmc_pkg::OP_READ, 15, 15, 0, 0, 0);
    queue_item(rdmc_pkg::OP_READ, 31, 31, 0, 0, 0);
    queue_item(rdmc_pkg::OP_READ, 15, 14, 0, 0, 0);
    queue_item(rdmc_pkg::OP_START, 0, 0, 0, 0, 0);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 0, 0, 0);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 3, 3, 1);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 1, 2, 0);
    queue_item(rdmc_pkg::OP_READ, 0, 0, 0, 0, 0);
    queue_item(rdmc_pkg::OP_NONE, 0, 0, 0, 0, 0);
    queue_item(rdmc_pkg::OP_STEP, 0, 0, 2, 1, 1);

    phase = 0;
    while (item_total < ITEM_GOAL) begin
      queue_ctl(ACT_DRAIN, '0, 0);
      if (phase < 8) begin
        cur_w = plan_w[phase];
        cur_h = plan_h[phase];
        queue_ctl(ACT_CFG, rdmc_pkg::CFG_GRID_WIDTH, cur_w);
        queue_ctl(ACT_CFG, rdmc_pkg::CFG_GRID_HEIGHT, cur_h);
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          cur_w = pick_size();
          queue_ctl(ACT_CFG, rdmc_pkg::CFG_GRID_WIDTH, cur_w);
        end
        if ($urandom_range(0, 3) != 0) begin
          cur_h = pick_size();
          queue_ctl(ACT_CFG, rdmc_pkg::CFG_GRID_HEIGHT, cur_h);
        end
      end
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      w_eff = (cur_w > rdmc_pkg::COORD_SPAN) ? rdmc_pkg::COORD_SPAN : cur_w;
      h_eff = (cur_h > rdmc_pkg::COORD_SPAN) ? rdmc_pkg::COORD_SPAN : cur_h;
      if (phase < 8 || $urandom_range(0, 4) != 0)
        queue_item(rdmc_pkg::OP_START, pick_coord(w_eff), pick_coord(h_eff),
                   $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1));
      n_steps = w_eff * h_eff + 2;
      if (n_steps > 48) n_steps = 48;
      for (int i = 0; i < n_steps; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15)
          queue_item(rdmc_pkg::OP_READ, pick_coord(w_eff), pick_coord(h_eff),
                     $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1));
        else if (r < 18)
          queue_item(rdmc_pkg::OP_START, $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1));
        else if (r < 21)
          queue_item(rdmc_pkg::OP_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1));
        else if (r < 23)
          queue_ctl(ACT_DRAIN, '0, 0);
        queue_item(rdmc_pkg::OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1));
      end
      phase++;
    end

    while (accepted_total != queued_total) @(posedge clk_i);
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    while (outcomes_due.size() != 0) log_fault("missing result", outcomes_due.pop_front(), '0);
    if (fault_cnt == 0) begin
      $display("random_dfs_maze_carver: match");
    end else begin
      $display("random_dfs_maze_carver: mismatch");
    end
    $finish;
  end

endmodule
